[hdl/lfia_pkg.sv]
package lfia_pkg;

  localparam int ID_W     = 10;
  localparam int ID_SPAN  = 1024;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;

  // position of the lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

[hdl/lowest_free_id_allocator_top.sv]
// Lowest free identifier allocator.
// A request accepted in S_IDLE reads one 32-bit bitmap word of the single-port
// memory; in S_EXEC, once the output register is free, the result is registered
// and the word written back. No new request is taken until then.
// Reset (rst_n low, synchronous): all identifiers free at once; per-word valid
// flags make unwritten words read as free, so there is no clearing pass.
module lowest_free_id_allocator_top #(
  parameter int NUM_IDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [lfia_pkg::ID_W-1:0]     in_release_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfia_pkg::ID_W-1:0]     out_granted_id,
  output logic [lfia_pkg::STATUS_W-1:0] out_status
);

  // Pool is limited by the reach of the 10-bit identifier fields.
  localparam int POOL_SIZE = (NUM_IDS < lfia_pkg::ID_SPAN) ? NUM_IDS : lfia_pkg::ID_SPAN;
  // Bitmap words of 32 identifiers each; summary holds one bit per word.
  localparam int NW  = (POOL_SIZE + lfia_pkg::WORD_W - 1) / lfia_pkg::WORD_W;
  localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
  localparam int REM = POOL_SIZE % lfia_pkg::WORD_W;
  // Last word only holds the identifiers that exist in the pool.
  localparam logic [lfia_pkg::WORD_W-1:0] LAST_MASK =
    (REM == 0) ? {lfia_pkg::WORD_W{1'b1}} : ((32'd1 << REM) - 32'd1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  // Value of a word that was never written since reset: every identifier free.
  function automatic logic [lfia_pkg::WORD_W-1:0] word_init(input logic [WIW-1:0] w);
    return (w == WIW'(NW - 1)) ? LAST_MASK : {lfia_pkg::WORD_W{1'b1}};
  endfunction

  // Lowest word with at least one free identifier.
  function automatic logic [WIW-1:0] lowest_word(input logic [NW-1:0] s);
    logic [WIW-1:0] pos;
    pos = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (s[i]) pos = WIW'(i);
    end
    return pos;
  endfunction

  // Bitmap memory, one read-modify-write at a time.
  logic [lfia_pkg::WORD_W-1:0] mem [NW];
  logic [lfia_pkg::WORD_W-1:0] rd_data_r;

  state_t                        state_r;
  logic [NW-1:0]                 valid_r;   // word has been written since reset
  logic [NW-1:0]                 sum_r;     // word holds a free identifier
  logic                          op_r;
  logic [lfia_pkg::BIT_W-1:0]    bit_r;
  logic [WIW-1:0]                word_r;
  logic                          empty_r;
  logic                          oor_r;     // release outside the pool
  logic                          rd_vld_r;
  logic                          out_valid_r;
  logic [lfia_pkg::ID_W-1:0]     gid_r;
  logic [lfia_pkg::STATUS_W-1:0] status_r;

  logic                          in_fire;
  logic                          oor_in;
  logic [WIW-1:0]                rd_addr;
  logic                          out_free;
  logic                          exec_fire;
  logic [lfia_pkg::WORD_W-1:0]   word_q;
  logic [lfia_pkg::BIT_W-1:0]    lo_bit;
  logic                          wr_en;
  logic [lfia_pkg::WORD_W-1:0]   wr_data;
  logic [lfia_pkg::ID_W-1:0]     gid_nxt;
  logic [lfia_pkg::STATUS_W-1:0] status_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign exec_fire = (state_r == S_EXEC) && out_free;

  assign out_valid      = out_valid_r;
  assign out_granted_id = gid_r;
  assign out_status     = status_r;

  assign oor_in = {1'b0, in_release_id} >= (lfia_pkg::ID_W + 1)'(POOL_SIZE);

  // Read address: lowest nonempty word on allocate, the identifier's word on release.
  always_comb begin
    if (in_opcode == lfia_pkg::OP_ALLOC) begin
      rd_addr = lowest_word(sum_r);
    end else if (oor_in) begin
      rd_addr = '0;
    end else begin
      rd_addr = in_release_id[lfia_pkg::BIT_W +: WIW];
    end
  end

  // Current word contents, with unwritten words taken as all free.
  assign word_q = rd_vld_r ? rd_data_r : word_init(word_r);
  assign lo_bit = lfia_pkg::lowest_set(word_q);

  always_comb begin
    wr_en      = 1'b0;
    wr_data    = word_q;
    gid_nxt    = '0;
    status_nxt = lfia_pkg::ST_DONE;
    if (op_r == lfia_pkg::OP_ALLOC) begin
      if (empty_r) begin
        status_nxt = lfia_pkg::ST_EMPTY;
      end else begin
        wr_en   = 1'b1;
        wr_data = word_q & ~(lfia_pkg::WORD_W'(1) << lo_bit);
        gid_nxt = lfia_pkg::ID_W'({word_r, lo_bit});
      end
    end else begin
      if (oor_r || word_q[bit_r]) begin
        status_nxt = lfia_pkg::ST_ALREADY_FREE;
      end else begin
        wr_en   = 1'b1;
        wr_data = word_q | (lfia_pkg::WORD_W'(1) << bit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[rd_addr];
    end
    if (exec_fire && wr_en) begin
      mem[word_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      sum_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r     <= in_opcode;
            bit_r    <= in_release_id[lfia_pkg::BIT_W-1:0];
            word_r   <= rd_addr;
            empty_r  <= ~|sum_r;
            oor_r    <= oor_in;
            rd_vld_r <= valid_r[rd_addr];
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (wr_en) begin
              valid_r[word_r] <= 1'b1;
              sum_r[word_r]   <= |wr_data;
            end
            gid_r       <= gid_nxt;
            status_r    <= status_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
